@@ rtl/core/tcw_pkg.sv @@
// shared constants, codes and types of the text console writer
`default_nettype none
package tcw_pkg;

    localparam int ROWS   = 25;
    localparam int COLS   = 80;
    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_NEWLINE       = 8'd10;
    localparam logic [7:0] CHAR_SPACE         = 8'd32;
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'h0f;

    typedef enum logic [1:0] {
        CMD_WRITE_CURSOR = 2'd0,
        CMD_WRITE_AT     = 2'd1,
        CMD_CLEAR        = 2'd2,
        CMD_READ         = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             at_cursor;
        logic             newline;
        logic [7:0]       character;
        logic [7:0]       attribute;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_op;

endpackage
`default_nettype wire

@@ rtl/core/tcw_front.sv @@
// front end: accepts commands and classifies them into queued operations
`default_nettype none
module tcw_front (
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    i_command,
    input  wire logic [7:0]    i_character,
    input  wire logic [7:0]    i_attribute,
    input  wire logic [4:0]    i_target_row,
    input  wire logic [6:0]    i_target_col,
    input  wire logic [7:0]    i_default_attr,
    input  wire logic          i_queue_full,
    input  wire logic          i_init_busy,
    output logic               o_push,
    output tcw_pkg::t_op       o_op
);

    logic w_in_range;

    assign busy       = i_queue_full | i_init_busy;
    assign o_push     = start & ~busy;
    assign w_in_range = (32'(i_target_row) < tcw_pkg::ROWS)
                      && (32'(i_target_col) < tcw_pkg::COLS);

    always_comb begin
        o_op.at_cursor = 1'b0;
        o_op.newline   = (i_character == tcw_pkg::CHAR_NEWLINE);
        o_op.character = i_character;
        o_op.attribute = (i_attribute == 8'd0) ? i_default_attr : i_attribute;
        o_op.row       = tcw_pkg::ROW_W'(i_target_row);
        o_op.col       = tcw_pkg::COL_W'(i_target_col);
        unique case (tcw_pkg::t_cmd'(i_command))
            tcw_pkg::CMD_WRITE_CURSOR: begin
                o_op.kind      = tcw_pkg::OP_WRITE;
                o_op.at_cursor = 1'b1;
            end
            tcw_pkg::CMD_WRITE_AT: begin
                o_op.kind = w_in_range ? tcw_pkg::OP_WRITE : tcw_pkg::OP_ERROR;
            end
            tcw_pkg::CMD_CLEAR: begin
                o_op.kind = tcw_pkg::OP_CLEAR;
            end
            tcw_pkg::CMD_READ: begin
                o_op.kind = w_in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_ERROR;
            end
            default: begin
                o_op.kind = tcw_pkg::OP_ERROR;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/tcw_queue.sv @@
// short operation queue between the front end and the back end
`default_nettype none
module tcw_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tcw_pkg::t_op  i_op,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output tcw_pkg::t_op       o_op
);

    tcw_pkg::t_op                r_slot [tcw_pkg::QDEPTH];
    logic [tcw_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [tcw_pkg::QCNT_W-1:0]  r_count, n_count;
    logic                        w_push;
    logic                        w_pop;

    function automatic logic [tcw_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tcw_pkg::QPTR_W-1:0] ptr
    );
        ptr_inc = (ptr == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full  = (r_count == tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = w_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = w_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tcw_back.sv @@
// back end: cell store, cursor, scroll and clear sequencer, result register
`default_nettype none
module tcw_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_default_attr,
    input  wire logic          i_op_valid,
    input  wire tcw_pkg::t_op  i_op,
    output logic               o_pop,
    output logic               o_init_busy,
    output logic               o_done,
    output logic [4:0]         o_cursor_row,
    output logic [6:0]         o_cursor_col,
    output logic               o_scrolled,
    output logic [7:0]         o_read_character,
    output logic [7:0]         o_read_attribute,
    output logic               o_position_error
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ADDR   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_RDWAIT = 6'b001000,
        S_BLANK  = 6'b010000,
        S_FILL   = 6'b100000
    } t_state;

    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;

    t_state              r_state, n_state;
    tcw_pkg::t_op        r_op, n_op;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_prow, n_prow;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_base, n_base;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_blank_base, n_blank_base;
    logic                r_clear, n_clear;
    logic                r_done, n_done;
    logic                r_scrolled, n_scrolled;
    logic                r_err, n_err;
    logic [7:0]          r_rd_char, n_rd_char;
    logic [7:0]          r_rd_attr, n_rd_attr;
    logic [15:0]         r_rd_data;
    logic [15:0]         r_mem [tcw_pkg::CELLS];

    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_mem_addr;
    logic [15:0]         w_mem_wdata;
    logic [ROW_W-1:0]    w_src_row;
    logic [ROW_W:0]      w_row_sum;
    logic [ROW_W-1:0]    w_prow;
    logic [COL_W-1:0]    w_col_inc;
    logic [ROW_W-1:0]    w_row_inc;
    logic                w_wrap;
    logic                w_last;

    assign w_src_row = i_op.at_cursor ? r_cur_row : i_op.row;
    assign w_row_sum = {1'b0, w_src_row} + {1'b0, r_base};
    assign w_prow    = (w_row_sum >= (ROW_W + 1)'(tcw_pkg::ROWS))
                     ? ROW_W'(w_row_sum - (ROW_W + 1)'(tcw_pkg::ROWS))
                     : ROW_W'(w_row_sum);
    assign w_col_inc = r_col + 1'b1;
    assign w_row_inc = r_row + 1'b1;
    assign w_wrap    = r_op.newline || (w_col_inc == COL_W'(tcw_pkg::COLS));
    assign w_last    = w_wrap && (w_row_inc == ROW_W'(tcw_pkg::ROWS));

    assign o_pop       = (r_state == S_IDLE) && i_op_valid;
    assign o_init_busy = (r_state == S_FILL) && !r_clear;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_row        = r_row;
        n_col        = r_col;
        n_prow       = r_prow;
        n_addr       = r_addr;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_blank_base = r_blank_base;
        n_clear      = r_clear;
        n_done       = 1'b0;
        n_scrolled   = 1'b0;
        n_err        = 1'b0;
        n_rd_char    = 8'd0;
        n_rd_attr    = 8'd0;
        w_mem_we     = 1'b0;
        w_mem_addr   = r_addr;
        w_mem_wdata  = {r_op.attribute, r_op.character};
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    n_op   = i_op;
                    n_row  = w_src_row;
                    n_col  = i_op.at_cursor ? r_cur_col : i_op.col;
                    n_prow = w_prow;
                    unique case (i_op.kind)
                        tcw_pkg::OP_WRITE, tcw_pkg::OP_READ: begin
                            n_state = S_ADDR;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_clear   = 1'b1;
                            n_cnt     = '0;
                            n_cur_row = '0;
                            n_cur_col = '0;
                            n_base    = '0;
                            n_state   = S_FILL;
                        end
                        default: begin
                            n_done = 1'b1;
                            n_err  = 1'b1;
                        end
                    endcase
                end
            end
            S_ADDR: begin
                n_addr  = ADDR_W'(ADDR_W'(r_prow) * ADDR_W'(tcw_pkg::COLS))
                        + ADDR_W'(r_col);
                n_state = S_EXEC;
            end
            S_EXEC: begin
                w_mem_addr = r_addr;
                if (r_op.kind == tcw_pkg::OP_READ) begin
                    n_state = S_RDWAIT;
                end else begin
                    w_mem_we = !r_op.newline;
                    if (w_last) begin
                        n_cur_row    = ROW_W'(tcw_pkg::ROWS - 1);
                        n_cur_col    = '0;
                        n_blank_base = ADDR_W'(ADDR_W'(r_base) * ADDR_W'(tcw_pkg::COLS));
                        n_base       = (r_base == ROW_W'(tcw_pkg::ROWS - 1))
                                     ? '0 : r_base + 1'b1;
                        n_cnt        = '0;
                        n_state      = S_BLANK;
                    end else begin
                        n_cur_row = w_wrap ? w_row_inc : r_row;
                        n_cur_col = w_wrap ? '0 : w_col_inc;
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_RDWAIT: begin
                n_done    = 1'b1;
                n_rd_char = r_rd_data[7:0];
                n_rd_attr = r_rd_data[15:8];
                n_state   = S_IDLE;
            end
            S_BLANK: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_blank_base + r_cnt;
                w_mem_wdata = 16'h0000;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(tcw_pkg::COLS - 1)) begin
                    n_done     = 1'b1;
                    n_scrolled = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FILL: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_cnt;
                w_mem_wdata = r_clear ? {i_default_attr, tcw_pkg::CHAR_SPACE} : 16'h0000;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(tcw_pkg::CELLS - 1)) begin
                    n_done  = r_clear;
                    n_clear = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_clear   <= 1'b0;
            r_cnt     <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_base    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clear   <= n_clear;
            r_cnt     <= n_cnt;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_base    <= n_base;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_row        <= n_row;
        r_col        <= n_col;
        r_prow       <= n_prow;
        r_addr       <= n_addr;
        r_blank_base <= n_blank_base;
        r_scrolled   <= n_scrolled;
        r_err        <= n_err;
        r_rd_char    <= n_rd_char;
        r_rd_attr    <= n_rd_attr;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_mem_addr];
    end

    assign o_done           = r_done;
    assign o_cursor_row     = 5'(r_cur_row);
    assign o_cursor_col     = 7'(r_cur_col);
    assign o_scrolled       = r_scrolled;
    assign o_read_character = r_rd_char;
    assign o_read_attribute = r_rd_attr;
    assign o_position_error = r_err;

endmodule
`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// top level of the text console writer
`default_nettype none
// Text console writer: a 25 by 80 store of character/attribute cells with a cursor.
// A command is taken when start is high and busy is low; every item gives one
// result on the o_ ports, marked by o_done for exactly one cycle, and the receiver
// cannot hold it off. Commands wait in a two-entry queue; busy rises when the
// queue is full. A write passes the queue slot and the idle, address and execute
// states, a read adds a read-wait state and a rejected position is answered from
// idle; these follow the single-port cell store sequencer, which handles one item
// at a time. A write that scrolls also blanks one row (rows are addressed through
// a rotating base, so nothing is copied); a clear writes one cell per cycle. After
// reset busy stays high for a clearing pass over the store. The default attribute
// register may be written at any time the block has no work pending.
module text_console_writer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_character,
    input  wire logic [7:0]  i_attribute,
    input  wire logic [4:0]  i_target_row,
    input  wire logic [6:0]  i_target_col,
    output logic             o_done,
    output logic [4:0]       o_cursor_row,
    output logic [6:0]       o_cursor_col,
    output logic             o_scrolled,
    output logic [7:0]       o_read_character,
    output logic [7:0]       o_read_attribute,
    output logic             o_position_error
);

    logic [7:0]    r_default_attr;
    logic          w_push;
    tcw_pkg::t_op  w_push_op;
    logic          w_full;
    logic          w_pop;
    logic          w_op_valid;
    tcw_pkg::t_op  w_head_op;
    logic          w_init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= tcw_pkg::DEFAULT_ATTR_RESET;
        end else if (i_cfg_we) begin
            r_default_attr <= i_cfg_wdata;
        end
    end

    tcw_front u_front (
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_character    (i_character),
        .i_attribute    (i_attribute),
        .i_target_row   (i_target_row),
        .i_target_col   (i_target_col),
        .i_default_attr (r_default_attr),
        .i_queue_full   (w_full),
        .i_init_busy    (w_init_busy),
        .o_push         (w_push),
        .o_op           (w_push_op)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_op_valid),
        .o_op    (w_head_op)
    );

    tcw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_default_attr   (r_default_attr),
        .i_op_valid       (w_op_valid),
        .i_op             (w_head_op),
        .o_pop            (w_pop),
        .o_init_busy      (w_init_busy),
        .o_done           (o_done),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_col     (o_cursor_col),
        .o_scrolled       (o_scrolled),
        .o_read_character (o_read_character),
        .o_read_attribute (o_read_attribute),
        .o_position_error (o_position_error)
    );

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_scroll_homes_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (o_cursor_col == 7'd0))
        else $error("scroll left cursor off column zero");

    a_error_no_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_position_error) |-> (!o_scrolled && o_read_character == 8'd0
                                          && o_read_attribute == 8'd0))
        else $error("rejected item scrolled or returned cell data");

endmodule
`default_nettype wire
